FILE: sv/cvtm_pkg.sv
// Package for the count vector transition matrix core.
// Holds field widths, item and config register codes, the queued command and result types and the FSM states.
// No dependencies.
package cvtm_pkg;

    localparam int SYM_W          = 4;
    localparam int NUM_SYMS       = 8;
    localparam int KEY_W          = 32;
    localparam int ACTION_W       = 2;
    localparam int SLOT_W         = 6;
    localparam int SLOT_SPAN      = 64;
    localparam int CLASS_W        = 4;
    localparam int CELL_W         = 32;
    localparam int SIZE_W         = 7;
    localparam int DIR_W          = 4;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 7;
    localparam int MAX_DIRS       = 8;
    localparam int MAX_HIST       = 8;
    localparam int QDEPTH         = 2;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int CLASSES_DEF     = 16;
    localparam int COUNT_WIDTH_DEF = 32;

    localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = 7'd0;
    localparam logic [DIR_W-1:0]  DIRS_RST       = 4'd8;
    localparam logic [DIR_W-1:0]  HIST_RST       = 4'd8;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD = 2'd0,
        ACT_DATA = 2'd1,
        ACT_READ = 2'd2,
        ACT_NOP  = 2'd3
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TABLE_SIZE = 2'd0,
        CFG_DIRS       = 2'd1,
        CFG_HIST       = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        BS_CLEAR,
        BS_IDLE,
        BS_CUR,
        BS_LOOK,
        BS_UPD,
        BS_RDOUT,
        BS_DONE
    } back_state_t;

    typedef struct packed {
        logic [SIZE_W-1:0] table_size;
        logic [DIR_W-1:0]  dirs;
        logic [DIR_W-1:0]  hist;
    } cfg_t;

    typedef struct packed {
        action_t            kind;
        logic [KEY_W-1:0]   key;
        logic               bad;
        logic [SLOT_W-1:0]  slot;
        logic [CLASS_W-1:0] cls;
        logic [CLASS_W-1:0] row;
        logic [CLASS_W-1:0] col;
    } cmd_t;

    typedef struct packed {
        logic [CELL_W-1:0] count;
        logic              counted;
        logic              error;
    } res_t;

endpackage

FILE: sv/cvtm_front.sv
// Front end: takes input items, counts direction symbols into a packed key and builds commands.
// Depends on cvtm_pkg.
module cvtm_front (
    input  logic                          push,
    output logic                          full,
    input  logic [cvtm_pkg::ACTION_W-1:0] action,
    input  logic [cvtm_pkg::KEY_W-1:0]    symbols,
    input  logic [cvtm_pkg::SLOT_W-1:0]   entry_slot,
    input  logic [cvtm_pkg::KEY_W-1:0]    entry_key,
    input  logic [cvtm_pkg::CLASS_W-1:0]  entry_class,
    input  logic [cvtm_pkg::CLASS_W-1:0]  read_row,
    input  logic [cvtm_pkg::CLASS_W-1:0]  read_col,
    input  cvtm_pkg::cfg_t                cfg,
    input  logic                          q_full,
    input  logic                          clearing,
    output logic                          q_push,
    output cvtm_pkg::cmd_t                q_data
);

    logic [cvtm_pkg::DIR_W-1:0] dirs_c;
    logic [cvtm_pkg::DIR_W-1:0] hist_c;
    logic [cvtm_pkg::KEY_W-1:0] calc_key;
    logic                       calc_bad;

    always_comb
    begin
        if (cfg.dirs == '0)
            dirs_c = cvtm_pkg::DIR_W'(1);
        else if (cfg.dirs > cvtm_pkg::DIR_W'(cvtm_pkg::MAX_DIRS))
            dirs_c = cvtm_pkg::DIR_W'(cvtm_pkg::MAX_DIRS);
        else
            dirs_c = cfg.dirs;

        if (cfg.hist == '0)
            hist_c = cvtm_pkg::DIR_W'(1);
        else if (cfg.hist > cvtm_pkg::DIR_W'(cvtm_pkg::MAX_HIST))
            hist_c = cvtm_pkg::DIR_W'(cvtm_pkg::MAX_HIST);
        else
            hist_c = cfg.hist;
    end

    // count each direction among the symbols in use
    always_comb
    begin
        logic [cvtm_pkg::SYM_W-1:0] sym;
        logic [cvtm_pkg::SYM_W-1:0] cnt;
        calc_key = '0;
        calc_bad = 1'b0;
        for (int d = 0; d < cvtm_pkg::MAX_DIRS; d++)
        begin
            cnt = '0;
            for (int i = 0; i < cvtm_pkg::NUM_SYMS; i++)
            begin
                sym = symbols[cvtm_pkg::SYM_W*i +: cvtm_pkg::SYM_W];
                if ((cvtm_pkg::DIR_W'(i) < hist_c) && (sym == cvtm_pkg::SYM_W'(d + 1))
                    && (cvtm_pkg::DIR_W'(d + 1) <= dirs_c))
                    cnt = cnt + cvtm_pkg::SYM_W'(1);
            end
            calc_key[cvtm_pkg::SYM_W*d +: cvtm_pkg::SYM_W] = cnt;
        end
        for (int i = 0; i < cvtm_pkg::NUM_SYMS; i++)
        begin
            sym = symbols[cvtm_pkg::SYM_W*i +: cvtm_pkg::SYM_W];
            if ((cvtm_pkg::DIR_W'(i) < hist_c) && ((sym == '0) || (sym > dirs_c)))
                calc_bad = 1'b1;
        end
    end

    always_comb
    begin
        full        = q_full || clearing;
        q_push      = push && !full;
        q_data.kind = cvtm_pkg::action_t'(action);
        q_data.key  = (q_data.kind == cvtm_pkg::ACT_LOAD) ? entry_key : calc_key;
        q_data.bad  = calc_bad;
        q_data.slot = entry_slot;
        q_data.cls  = entry_class;
        q_data.row  = read_row;
        q_data.col  = read_col;
    end

endmodule

FILE: sv/cvtm_fifo.sv
// Command queue between the front end and the back end.
// Depends on cvtm_pkg.
module cvtm_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  cvtm_pkg::cmd_t wr_data,
    output logic           q_full,
    input  logic           rd_en,
    output cvtm_pkg::cmd_t rd_data,
    output logic           q_empty
);

    localparam int PTR_W = (cvtm_pkg::QDEPTH > 1) ? $clog2(cvtm_pkg::QDEPTH) : 1;

    cvtm_pkg::cmd_t   q_mem [cvtm_pkg::QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   fill_reg, fill_next;

    always_comb
    begin
        q_full      = (fill_reg == (PTR_W + 1)'(cvtm_pkg::QDEPTH));
        q_empty     = (fill_reg == '0);
        rd_data     = q_mem[rd_ptr_reg];
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(cvtm_pkg::QDEPTH - 1)) ? '0
                          : wr_ptr_reg + PTR_W'(1);
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(cvtm_pkg::QDEPTH - 1)) ? '0
                          : rd_ptr_reg + PTR_W'(1);
        if (wr_en && !rd_en)
            fill_next = fill_reg + (PTR_W + 1)'(1);
        else if (rd_en && !wr_en)
            fill_next = fill_reg - (PTR_W + 1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            q_mem[wr_ptr_reg] <= wr_data;
    end

endmodule

FILE: sv/cvtm_back.sv
// Back end: key table search, transition count memory update, cell reads and result register.
// Depends on cvtm_pkg.
module cvtm_back #(
    parameter int TABLE_DEPTH = cvtm_pkg::TABLE_DEPTH_DEF,
    parameter int CLASSES     = cvtm_pkg::CLASSES_DEF,
    parameter int COUNT_WIDTH = cvtm_pkg::COUNT_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [cvtm_pkg::SIZE_W-1:0]   table_size,
    input  logic                          q_empty,
    input  cvtm_pkg::cmd_t                q_head,
    output logic                          q_pop,
    output logic                          clearing,
    input  logic                          pop,
    output logic                          empty,
    output logic [cvtm_pkg::CELL_W-1:0]   cell_count,
    output logic                          transition_counted,
    output logic                          error_seen
);

    localparam int SLOTS  = (TABLE_DEPTH < cvtm_pkg::SLOT_SPAN) ? TABLE_DEPTH
                            : cvtm_pkg::SLOT_SPAN;
    localparam int CELLS  = CLASSES * CLASSES;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;

    logic [cvtm_pkg::KEY_W-1:0]   keys_reg    [SLOTS];
    logic [cvtm_pkg::CLASS_W-1:0] classes_reg [SLOTS];
    logic [COUNT_WIDTH-1:0]       counts_mem  [CELLS];

    cvtm_pkg::back_state_t        state_reg, state_next;
    cvtm_pkg::cmd_t               cmd_reg, cmd_next;
    cvtm_pkg::res_t               res_reg, res_next;
    logic [SLOTS-1:0]             match_reg, match_next;
    logic                         row_ok_reg, row_ok_next;
    logic [cvtm_pkg::CLASS_W-1:0] row_reg, row_next;
    logic [ADDR_W-1:0]            addr_reg, addr_next;
    logic [ADDR_W-1:0]            clr_reg, clr_next;
    logic [cvtm_pkg::KEY_W-1:0]   prev_key_reg, prev_key_next;
    logic                         prev_bad_reg, prev_bad_next;
    logic                         have_prev_reg, have_prev_next;
    logic                         error_reg, error_next;
    logic                         out_valid_reg, out_valid_next;
    logic [COUNT_WIDTH-1:0]       rdata_reg;

    logic [cvtm_pkg::KEY_W-1:0]   search_key;
    logic [SLOTS-1:0]             match_vec;
    logic [SLOTS-1:0]             lowest;
    logic [cvtm_pkg::CLASS_W-1:0] hit_cls;
    logic                         hit_ok;
    logic                         res_free;
    logic                         res_load;
    logic                         tbl_we;
    logic                         mem_we;
    logic                         mem_re;
    logic [ADDR_W-1:0]            mem_addr;
    logic [COUNT_WIDTH-1:0]       mem_wdata;
    logic [COUNT_WIDTH-1:0]       cnt_new;
    logic [COUNT_WIDTH+31:0]      new_ext;
    logic [COUNT_WIDTH+31:0]      rd_ext;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [cvtm_pkg::CLASS_W-1:0] r,
                                                    input logic [cvtm_pkg::CLASS_W-1:0] c);
        cell_addr = ADDR_W'(r) * ADDR_W'(CLASSES) + ADDR_W'(c);
    endfunction

    function automatic logic in_range(input logic [cvtm_pkg::CLASS_W-1:0] r,
                                      input logic [cvtm_pkg::CLASS_W-1:0] c);
        in_range = (int'(r) < CLASSES) && (int'(c) < CLASSES);
    endfunction

    // key compare against every slot in use
    always_comb
    begin
        search_key = (state_reg == cvtm_pkg::BS_IDLE) ? prev_key_reg : cmd_reg.key;
        for (int i = 0; i < SLOTS; i++)
            match_vec[i] = (cvtm_pkg::SIZE_W'(i) < table_size) && (keys_reg[i] == search_key);
    end

    // first hit wins
    always_comb
    begin
        lowest  = match_reg & (~match_reg + SLOTS'(1));
        hit_cls = '0;
        for (int i = 0; i < SLOTS; i++)
            if (lowest[i])
                hit_cls = hit_cls | classes_reg[i];
        hit_ok = (|match_reg) && (int'(hit_cls) < CLASSES);
    end

    always_comb
    begin
        cnt_new = (&rdata_reg) ? rdata_reg : rdata_reg + COUNT_WIDTH'(1);
        new_ext = {32'b0, cnt_new};
        rd_ext  = {32'b0, rdata_reg};
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        match_next     = match_reg;
        row_ok_next    = row_ok_reg;
        row_next       = row_reg;
        addr_next      = addr_reg;
        clr_next       = clr_reg;
        prev_key_next  = prev_key_reg;
        prev_bad_next  = prev_bad_reg;
        have_prev_next = have_prev_reg;
        error_next     = error_reg;
        res_next       = res_reg;
        res_load       = 1'b0;
        q_pop          = 1'b0;
        tbl_we         = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_addr       = addr_reg;
        mem_wdata      = '0;
        res_free       = !out_valid_reg || pop;

        case (state_reg)
            cvtm_pkg::BS_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_addr = clr_reg;
                clr_next = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(CELLS - 1))
                    state_next = cvtm_pkg::BS_IDLE;
            end
            cvtm_pkg::BS_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    cmd_next   = q_head;
                    match_next = match_vec;
                    case (q_head.kind)
                        cvtm_pkg::ACT_DATA:
                            state_next = have_prev_reg ? cvtm_pkg::BS_CUR : cvtm_pkg::BS_DONE;
                        cvtm_pkg::ACT_READ:
                        begin
                            if (in_range(q_head.row, q_head.col))
                            begin
                                mem_re   = 1'b1;
                                mem_addr = cell_addr(q_head.row, q_head.col);
                            end
                            state_next = cvtm_pkg::BS_RDOUT;
                        end
                        default:
                            state_next = cvtm_pkg::BS_DONE;
                    endcase
                end
            end
            cvtm_pkg::BS_CUR:
            begin
                row_ok_next = hit_ok && !prev_bad_reg;
                row_next    = hit_cls;
                match_next  = match_vec;
                state_next  = cvtm_pkg::BS_LOOK;
            end
            cvtm_pkg::BS_LOOK:
            begin
                if (row_ok_reg && hit_ok && !cmd_reg.bad)
                begin
                    addr_next  = cell_addr(row_reg, hit_cls);
                    mem_re     = 1'b1;
                    mem_addr   = cell_addr(row_reg, hit_cls);
                    state_next = cvtm_pkg::BS_UPD;
                end
                else
                    state_next = cvtm_pkg::BS_DONE;
            end
            cvtm_pkg::BS_UPD:
            begin
                if (res_free)
                begin
                    mem_we           = 1'b1;
                    mem_wdata        = cnt_new;
                    res_load         = 1'b1;
                    res_next.count   = new_ext[cvtm_pkg::CELL_W-1:0];
                    res_next.counted = 1'b1;
                    res_next.error   = error_reg;
                    prev_key_next    = cmd_reg.key;
                    prev_bad_next    = cmd_reg.bad;
                    have_prev_next   = 1'b1;
                    state_next       = cvtm_pkg::BS_IDLE;
                end
            end
            cvtm_pkg::BS_RDOUT:
            begin
                if (res_free)
                begin
                    res_load         = 1'b1;
                    res_next.count   = in_range(cmd_reg.row, cmd_reg.col)
                                       ? rd_ext[cvtm_pkg::CELL_W-1:0] : '0;
                    res_next.counted = 1'b0;
                    res_next.error   = error_reg;
                    state_next       = cvtm_pkg::BS_IDLE;
                end
            end
            cvtm_pkg::BS_DONE:
            begin
                if (res_free)
                begin
                    case (cmd_reg.kind)
                        cvtm_pkg::ACT_LOAD:
                            tbl_we = 1'b1;
                        cvtm_pkg::ACT_DATA:
                        begin
                            error_next     = error_reg | have_prev_reg;
                            prev_key_next  = cmd_reg.key;
                            prev_bad_next  = cmd_reg.bad;
                            have_prev_next = 1'b1;
                        end
                        default:
                            ;
                    endcase
                    res_load         = 1'b1;
                    res_next.count   = '0;
                    res_next.counted = 1'b0;
                    res_next.error   = error_next;
                    state_next       = cvtm_pkg::BS_IDLE;
                end
            end
            default:
                state_next = cvtm_pkg::BS_IDLE;
        endcase

        if (res_load)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cvtm_pkg::BS_CLEAR;
            clr_reg       <= '0;
            prev_key_reg  <= '0;
            prev_bad_reg  <= 1'b0;
            have_prev_reg <= 1'b0;
            error_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            prev_key_reg  <= prev_key_next;
            prev_bad_reg  <= prev_bad_next;
            have_prev_reg <= have_prev_next;
            error_reg     <= error_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        match_reg  <= match_next;
        row_ok_reg <= row_ok_next;
        row_reg    <= row_next;
        addr_reg   <= addr_next;
        res_reg    <= res_next;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            if (tbl_we && (cmd_reg.slot == cvtm_pkg::SLOT_W'(i)))
            begin
                keys_reg[i]    <= cmd_reg.key;
                classes_reg[i] <= cmd_reg.cls;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            counts_mem[mem_addr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= counts_mem[mem_addr];
    end

    assign clearing           = (state_reg == cvtm_pkg::BS_CLEAR);
    assign empty              = !out_valid_reg;
    assign cell_count         = res_reg.count;
    assign transition_counted = res_reg.counted;
    assign error_seen         = res_reg.error;

    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        error_reg |=> error_reg)
        else $error("error flag dropped");

    a_single_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("count memory read and written in one cycle");

    a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cvtm_pkg::BS_CLEAR) |-> !q_pop)
        else $error("command taken during clearing pass");

    a_count_no_err: assert property (@(posedge clk) disable iff (!rst_n)
        (res_load && res_next.counted) |-> (error_next == error_reg))
        else $error("counted transition changed error flag");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pop) |=> (out_valid_reg && $stable(res_reg)))
        else $error("waiting result lost or changed");

endmodule

FILE: sv/count_vector_transition_matrix_core.sv
// Top level of the count vector transition matrix core.
// Holds the configuration registers; depends on cvtm_pkg, cvtm_front, cvtm_fifo, cvtm_back.
//
//   channel   handshake              payload
//   input     push / full            action symbols entry_slot entry_key entry_class
//                                    read_row read_col
//   result    empty / pop            cell_count transition_counted error_seen
//   config    cfg_valid / cfg_ready  cfg_index cfg_data
//
// In the back end, load, unused and first data items go to BS_DONE, reads to BS_RDOUT.
// A data item with a previous vector goes to BS_CUR, BS_LOOK and, on a hit, BS_UPD: the
// key table is compared against the previous key, then the current key, then the count
// memory is read and written back. A clearing pass after reset zeroes it; full is high.
// A two-entry command queue and the result register let input and output stall independently.
module count_vector_transition_matrix_core #(
    parameter int TABLE_DEPTH = cvtm_pkg::TABLE_DEPTH_DEF,
    parameter int CLASSES     = cvtm_pkg::CLASSES_DEF,
    parameter int COUNT_WIDTH = cvtm_pkg::COUNT_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [cvtm_pkg::ACTION_W-1:0]   action,
    input  logic [cvtm_pkg::KEY_W-1:0]      symbols,
    input  logic [cvtm_pkg::SLOT_W-1:0]     entry_slot,
    input  logic [cvtm_pkg::KEY_W-1:0]      entry_key,
    input  logic [cvtm_pkg::CLASS_W-1:0]    entry_class,
    input  logic [cvtm_pkg::CLASS_W-1:0]    read_row,
    input  logic [cvtm_pkg::CLASS_W-1:0]    read_col,
    output logic                            empty,
    input  logic                            pop,
    output logic [cvtm_pkg::CELL_W-1:0]     cell_count,
    output logic                            transition_counted,
    output logic                            error_seen,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cvtm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cvtm_pkg::CFG_DATA_W-1:0] cfg_data
);

    cvtm_pkg::cfg_t cfg_reg, cfg_next;
    cvtm_pkg::cmd_t q_data;
    cvtm_pkg::cmd_t q_head;
    logic           q_push;
    logic           q_pop;
    logic           q_full;
    logic           q_empty;
    logic           clearing;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cvtm_pkg::cfg_reg_t'(cfg_index))
                cvtm_pkg::CFG_TABLE_SIZE: cfg_next.table_size = cfg_data;
                cvtm_pkg::CFG_DIRS:       cfg_next.dirs = cfg_data[cvtm_pkg::DIR_W-1:0];
                cvtm_pkg::CFG_HIST:       cfg_next.hist = cfg_data[cvtm_pkg::DIR_W-1:0];
                default:                  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.table_size <= cvtm_pkg::TABLE_SIZE_RST;
            cfg_reg.dirs       <= cvtm_pkg::DIRS_RST;
            cfg_reg.hist       <= cvtm_pkg::HIST_RST;
        end
        else
            cfg_reg <= cfg_next;
    end

    cvtm_front u_front (
        .push        (push),
        .full        (full),
        .action      (action),
        .symbols     (symbols),
        .entry_slot  (entry_slot),
        .entry_key   (entry_key),
        .entry_class (entry_class),
        .read_row    (read_row),
        .read_col    (read_col),
        .cfg         (cfg_reg),
        .q_full      (q_full),
        .clearing    (clearing),
        .q_push      (q_push),
        .q_data      (q_data)
    );

    cvtm_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_data),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_data (q_head),
        .q_empty (q_empty)
    );

    cvtm_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .CLASSES     (CLASSES),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .table_size         (cfg_reg.table_size),
        .q_empty            (q_empty),
        .q_head             (q_head),
        .q_pop              (q_pop),
        .clearing           (clearing),
        .pop                (pop),
        .empty              (empty),
        .cell_count         (cell_count),
        .transition_counted (transition_counted),
        .error_seen         (error_seen)
    );

endmodule
